// ===== rtl/core/psdm_pkg.sv =====
// psdm_pkg: item types, register indexes, constants and helpers shared by the
// pressure sensor depth monitor; depends on nothing else
package psdm_pkg;

    // input item: one raw pressure and temperature pair
    typedef struct packed {
        logic [15:0] raw_pressure;
        logic [15:0] raw_temperature;
    } t_in_item;

    // result item
    typedef struct packed {
        logic signed [15:0] temperature_tenths;
        logic signed [15:0] pressure_tenths;
        logic [12:0]        depth_cm;
        logic               depth_valid;
        logic               alarm_on;
    } t_out_item;

    // configuration register indexes
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 16;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_CAL_WORD_ONE   = 3'd0,
        CFG_CAL_WORD_TWO   = 3'd1,
        CFG_CAL_WORD_THREE = 3'd2,
        CFG_CAL_WORD_FOUR  = 3'd3,
        CFG_ALARM_DEPTH_CM = 3'd4,
        CFG_LOCK_TOLERANCE = 3'd5
    } t_cfg_index;

    // register reset values
    localparam logic [12:0] ALARM_DEPTH_RST = 13'd2;
    localparam logic [9:0]  LOCK_TOL_RST    = 10'd10;

    // compensation constants
    localparam logic [15:0]        TEMP_CAL_BASE = 16'd20224;
    localparam logic signed [17:0] PRES_D1_BASE  = 18'sd7168;
    localparam logic signed [18:0] SENS_BASE     = 19'sd24576;
    localparam logic signed [10:0] OFF_TC_MID    = 11'sd512;
    localparam logic signed [21:0] PRES_BASE     = 22'sd2500;
    localparam logic signed [16:0] TEMP_BASE     = 17'sd200;
    localparam logic [6:0]         TEMP_COEF_ADD = 7'd50;
    localparam logic [4:0]         PRES_SCALE    = 5'd10;
    localparam logic [6:0]         DEPTH_NUM     = 7'd100;

    // floor(n / 981) == (n * DEPTH_RECIP) >> DEPTH_SHIFT exactly for n < 2^23
    localparam logic [23:0] DEPTH_RECIP = 24'd8756305;
    localparam int unsigned DEPTH_SHIFT = 33;

    // lock phases
    localparam logic [1:0] PHASE_NONE   = 2'd0;
    localparam logic [1:0] PHASE_TAKEN  = 2'd1;
    localparam logic [1:0] PHASE_LOCKED = 2'd2;

    // saturate to 16-bit signed
    function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
        logic signed [15:0] res;
        if (v > 24'sd32767) begin
            res = 16'sh7FFF;
        end else if (v < -24'sd32768) begin
            res = 16'sh8000;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/pressure_sensor_depth_monitor_top.sv =====
// pressure_sensor_depth_monitor_top: first-order pressure and temperature
// compensation with reference lock and depth alarm; depends on psdm_pkg
//
// sequence: TEMP, OFF, SENS, X, PRES, LOCK, then NUM and DEPTH once locked, then DONE
// items: one at a time, none accepted until back in IDLE, set by the single shared 25x25
//   multiplier that every product of the compensation and the depth scaling uses
// reset (synchronous, active low): registers to their defaults, lock phase to
//   no reference, reference 0, alarm held on, no result pending
module pressure_sensor_depth_monitor_top (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // configuration write port
    input  logic                                    i_cfg_we,
    input  logic [psdm_pkg::CFG_ADDR_W-1:0]         i_cfg_addr,
    input  logic [psdm_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    // input channel
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  psdm_pkg::t_in_item                      i_in_item,
    // result channel
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output psdm_pkg::t_out_item                     o_out_item
);

    // sequencer: at most one multiply per step on the shared unit
    typedef enum logic [3:0] {
        S_IDLE,
        S_TEMP,     // dT * (c6 + 50)
        S_OFF,      // (c4 - 512) * dT
        S_SENS,     // c3 * dT
        S_X,        // sens * (d1 - 7168)
        S_PRES,     // x * 10
        S_LOCK,     // reference lock, no multiply
        S_NUM,      // |p - ref| * 100
        S_DEPTH,    // scaled numerator * reciprocal of 981
        S_DONE      // wait for the result register
    } t_state;

    t_state r_state;

    // configuration registers
    logic [15:0] r_cal_one, r_cal_two, r_cal_three, r_cal_four;
    logic [12:0] r_alarm_depth;
    logic [9:0]  r_lock_tol;

    // persistent monitor state
    logic [1:0]         r_phase;
    logic signed [15:0] r_ref;
    logic               r_alarm;

    // per-item working registers
    logic [15:0]        r_d1;
    logic signed [17:0] r_dt;
    logic signed [15:0] r_temp;
    logic signed [17:0] r_off;
    logic signed [18:0] r_sens;
    logic signed [22:0] r_x;
    logic signed [15:0] r_pres;
    logic [16:0]        r_diff;
    logic [22:0]        r_num;
    logic [12:0]        r_depth;
    logic               r_dvalid;

    // result register
    logic      r_o_valid;
    psdm_pkg::t_out_item r_o_item;

    // coefficients unpacked from the calibration words
    logic [14:0] w_c1;
    logic [11:0] w_c2;
    logic [9:0]  w_c3, w_c4;
    logic [10:0] w_c5;
    logic [5:0]  w_c6;

    assign w_c1 = r_cal_one[15:1];
    assign w_c2 = {r_cal_three[5:0], r_cal_four[5:0]};
    assign w_c3 = r_cal_four[15:6];
    assign w_c4 = r_cal_three[15:6];
    assign w_c5 = {r_cal_one[0], r_cal_two[15:6]};
    assign w_c6 = r_cal_two[5:0];

    // dT from the shifted temperature word, taken at accept
    logic [15:0]        w_d2;
    logic [15:0]        w_tbase;
    logic signed [17:0] n_dt;

    assign w_d2    = {i_in_item.raw_temperature[14:0], 1'b0};
    assign w_tbase = {2'b00, w_c5, 3'b000} + psdm_pkg::TEMP_CAL_BASE;
    assign n_dt    = $signed({2'b00, w_d2}) - $signed({2'b00, w_tbase});

    // shared multiplier with operand select
    logic signed [24:0] w_ma, w_mb;
    logic signed [49:0] w_prod;

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_TEMP: begin
                w_ma = 25'(r_dt);
                w_mb = $signed({18'b0, {1'b0, w_c6} + psdm_pkg::TEMP_COEF_ADD});
            end
            S_OFF: begin
                w_ma = 25'(r_dt);
                w_mb = 25'($signed({1'b0, w_c4}) - psdm_pkg::OFF_TC_MID);
            end
            S_SENS: begin
                w_ma = 25'(r_dt);
                w_mb = $signed({15'b0, w_c3});
            end
            S_X: begin
                w_ma = 25'(r_sens);
                w_mb = 25'($signed({2'b00, r_d1}) - psdm_pkg::PRES_D1_BASE);
            end
            S_PRES: begin
                w_ma = 25'(r_x);
                w_mb = $signed({20'b0, psdm_pkg::PRES_SCALE});
            end
            S_NUM: begin
                w_ma = $signed({8'b0, r_diff});
                w_mb = $signed({18'b0, psdm_pkg::DEPTH_NUM});
            end
            S_DEPTH: begin
                w_ma = $signed({2'b00, r_num});
                w_mb = $signed({1'b0, psdm_pkg::DEPTH_RECIP});
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_prod = w_ma * w_mb;

    // floor shifts of the product
    logic signed [49:0] w_sh5, w_sh10, w_sh12, w_sh14;
    assign w_sh5  = w_prod >>> 5;
    assign w_sh10 = w_prod >>> 10;
    assign w_sh12 = w_prod >>> 12;
    assign w_sh14 = w_prod >>> 14;

    // post-add of each step
    logic signed [16:0] n_temp;
    logic signed [17:0] n_off;
    logic signed [18:0] n_sens;
    logic signed [22:0] n_x;
    logic signed [21:0] n_pres;
    logic [12:0]        n_depth;

    assign n_temp  = w_sh10[16:0] + psdm_pkg::TEMP_BASE;
    assign n_off   = $signed({4'b0000, w_c2, 2'b00}) + w_sh12[17:0];
    assign n_sens  = $signed({4'b0000, w_c1}) + w_sh10[18:0] + psdm_pkg::SENS_BASE;
    assign n_x     = w_sh14[22:0] - 23'(r_off);
    assign n_pres  = w_sh5[21:0] + psdm_pkg::PRES_BASE;
    assign n_depth = w_prod[psdm_pkg::DEPTH_SHIFT+12:psdm_pkg::DEPTH_SHIFT];

    // lock decision on the saturated pressure
    logic signed [16:0] w_err_s;
    logic [16:0]        w_err;
    logic               w_lock_fail;
    logic               w_locked;
    logic signed [15:0] w_ref_new;
    logic signed [16:0] w_diff_s;
    logic [16:0]        w_diff;

    assign w_err_s     = 17'(r_ref) - 17'(r_pres);
    assign w_err       = w_err_s[16] ? 17'(-w_err_s) : w_err_s;
    assign w_lock_fail = w_err > {7'b0, r_lock_tol};
    // locked after this item: already locked, or taken and within tolerance
    assign w_locked    = (r_phase != psdm_pkg::PHASE_NONE)
                         && !((r_phase == psdm_pkg::PHASE_TAKEN) && w_lock_fail);
    assign w_ref_new   = (r_phase == psdm_pkg::PHASE_NONE
                          || r_phase == psdm_pkg::PHASE_TAKEN) ? r_pres : r_ref;
    assign w_diff_s    = 17'(r_pres) - 17'(w_ref_new);
    assign w_diff      = w_diff_s[16] ? 17'(-w_diff_s) : w_diff_s;

    logic w_out_free;
    assign w_out_free = !r_o_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_cal_one     <= '0;
            r_cal_two     <= '0;
            r_cal_three   <= '0;
            r_cal_four    <= '0;
            r_alarm_depth <= psdm_pkg::ALARM_DEPTH_RST;
            r_lock_tol    <= psdm_pkg::LOCK_TOL_RST;
            r_phase       <= psdm_pkg::PHASE_NONE;
            r_ref         <= '0;
            r_alarm       <= 1'b1;
            r_o_valid     <= 1'b0;
        end else begin
            // configuration writes, indexes past the list are dropped
            if (i_cfg_we) begin
                case (psdm_pkg::t_cfg_index'(i_cfg_addr))
                    psdm_pkg::CFG_CAL_WORD_ONE:   r_cal_one     <= i_cfg_data;
                    psdm_pkg::CFG_CAL_WORD_TWO:   r_cal_two     <= i_cfg_data;
                    psdm_pkg::CFG_CAL_WORD_THREE: r_cal_three   <= i_cfg_data;
                    psdm_pkg::CFG_CAL_WORD_FOUR:  r_cal_four    <= i_cfg_data;
                    psdm_pkg::CFG_ALARM_DEPTH_CM: r_alarm_depth <= i_cfg_data[12:0];
                    psdm_pkg::CFG_LOCK_TOLERANCE: r_lock_tol    <= i_cfg_data[9:0];
                    default: ;
                endcase
            end

            // result taken downstream, unless a new one is loaded at this edge
            if (r_o_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_o_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_d1    <= {i_in_item.raw_pressure[14:0], 1'b0};
                        r_dt    <= n_dt;
                        r_state <= S_TEMP;
                    end
                end
                S_TEMP: begin
                    r_temp  <= psdm_pkg::sat16(24'(n_temp));
                    r_state <= S_OFF;
                end
                S_OFF: begin
                    r_off   <= n_off;
                    r_state <= S_SENS;
                end
                S_SENS: begin
                    r_sens  <= n_sens;
                    r_state <= S_X;
                end
                S_X: begin
                    r_x     <= n_x;
                    r_state <= S_PRES;
                end
                S_PRES: begin
                    r_pres  <= psdm_pkg::sat16(24'(n_pres));
                    r_state <= S_LOCK;
                end
                S_LOCK: begin
                    r_ref   <= w_ref_new;
                    r_diff  <= w_diff;
                    r_depth <= '0;
                    if (w_locked) begin
                        r_phase  <= psdm_pkg::PHASE_LOCKED;
                        r_dvalid <= 1'b1;
                        r_state  <= S_NUM;
                    end else begin
                        // first reading taken, or mismatch drops back to no reference
                        r_phase  <= (r_phase == psdm_pkg::PHASE_NONE)
                                    ? psdm_pkg::PHASE_TAKEN : psdm_pkg::PHASE_NONE;
                        r_dvalid <= 1'b0;
                        r_state  <= S_DONE;
                    end
                end
                S_NUM: begin
                    r_num   <= w_prod[22:0];
                    r_state <= S_DEPTH;
                end
                S_DEPTH: begin
                    r_depth <= n_depth;
                    r_alarm <= (n_depth <= r_alarm_depth);
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_o_item.temperature_tenths <= r_temp;
                        r_o_item.pressure_tenths    <= r_pres;
                        r_o_item.depth_cm           <= r_depth;
                        r_o_item.depth_valid        <= r_dvalid;
                        r_o_item.alarm_on           <= r_alarm;
                        r_o_valid                   <= 1'b1;
                        r_state                     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_o_valid;
    assign o_out_item  = r_o_item;

endmodule
